[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros on i_clk; SDES_ASSERT is disabled in the active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge of i_clk while out of reset
`define SDES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on each rising edge of i_clk, reset included
`define SDES_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[design/sdes_pkg.sv]
// ----------------------------------------------------------------------------
// sdes_pkg
// Permutation tables, S-boxes and round functions for simplified DES.
// ----------------------------------------------------------------------------
package sdes_pkg;

    localparam int unsigned KeyW   = 10;
    localparam int unsigned BlockW = 8;
    localparam int unsigned SubW   = 8;
    localparam int unsigned HalfW  = 4;

    typedef logic [KeyW-1:0]   t_key;
    typedef logic [BlockW-1:0] t_block;
    typedef logic [SubW-1:0]   t_subkey;
    typedef logic [HalfW-1:0]  t_half;

    // Table entries count bit positions from the most significant bit
    localparam logic [3:0] P10_TBL   [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
                                              4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
    localparam logic [3:0] P8_TBL    [8]  = '{4'd5, 4'd2, 4'd6, 4'd3,
                                              4'd7, 4'd4, 4'd9, 4'd8};
    localparam logic [2:0] IP_TBL    [8]  = '{3'd1, 3'd5, 3'd2, 3'd0,
                                              3'd3, 3'd7, 3'd4, 3'd6};
    localparam logic [2:0] IPINV_TBL [8]  = '{3'd3, 3'd0, 3'd2, 3'd4,
                                              3'd6, 3'd1, 3'd7, 3'd5};
    localparam logic [1:0] EP_TBL    [8]  = '{2'd3, 2'd0, 2'd1, 2'd2,
                                              2'd1, 2'd2, 2'd3, 2'd0};
    localparam logic [1:0] P4_TBL    [4]  = '{2'd1, 2'd3, 2'd2, 2'd0};

    // S-boxes, indexed by {row, column}
    localparam logic [1:0] SBOX_A [16] = '{
        2'd1, 2'd0, 2'd3, 2'd2,
        2'd3, 2'd2, 2'd1, 2'd0,
        2'd0, 2'd2, 2'd1, 2'd3,
        2'd3, 2'd1, 2'd0, 2'd2
    };
    localparam logic [1:0] SBOX_B [16] = '{
        2'd0, 2'd1, 2'd2, 2'd3,
        2'd2, 2'd3, 2'd1, 2'd0,
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd2, 2'd1, 2'd0, 2'd3
    };

    function automatic t_key f_p10(input t_key k);
        t_key o;
        for (int i = 0; i < 10; i++) begin
            o[9-i] = k[4'd9 - P10_TBL[i]];
        end
        return o;
    endfunction

    function automatic t_subkey f_p8(input t_key k);
        t_subkey o;
        for (int i = 0; i < 8; i++) begin
            o[7-i] = k[4'd9 - P8_TBL[i]];
        end
        return o;
    endfunction

    function automatic t_block f_ip(input t_block d);
        t_block o;
        for (int i = 0; i < 8; i++) begin
            o[7-i] = d[3'd7 - IP_TBL[i]];
        end
        return o;
    endfunction

    function automatic t_block f_ipinv(input t_block d);
        t_block o;
        for (int i = 0; i < 8; i++) begin
            o[7-i] = d[3'd7 - IPINV_TBL[i]];
        end
        return o;
    endfunction

    // Rotate each 5-bit half left by one
    function automatic t_key f_rot(input t_key k);
        return {k[8:5], k[9], k[3:0], k[4]};
    endfunction

    function automatic t_subkey f_subkey1(input t_key key);
        return f_p8(f_rot(f_p10(key)));
    endfunction

    function automatic t_subkey f_subkey2(input t_key key);
        return f_p8(f_rot(f_rot(f_p10(key))));
    endfunction

    function automatic t_half f_round(input t_half right, input t_subkey sub);
        t_subkey    e;
        logic [1:0] sa;
        logic [1:0] sb;
        t_half      s;
        t_half      o;
        for (int i = 0; i < 8; i++) begin
            e[7-i] = right[2'd3 - EP_TBL[i]];
        end
        e  = e ^ sub;
        sa = SBOX_A[{e[7], e[4], e[6], e[5]}];
        sb = SBOX_B[{e[3], e[0], e[2], e[1]}];
        s  = {sa, sb};
        for (int i = 0; i < 4; i++) begin
            o[3-i] = s[2'd3 - P4_TBL[i]];
        end
        return o;
    endfunction

    function automatic t_block f_encrypt(input t_block d, input t_subkey k1,
                                         input t_subkey k2);
        t_block blk;
        t_half  left;
        t_half  right;
        blk   = f_ip(d);
        // First round, swap halves, then second round
        left  = blk[3:0];
        right = blk[7:4] ^ f_round(blk[3:0], k1);
        left  = left ^ f_round(right, k2);
        return f_ipinv({left, right});
    endfunction

endpackage

[design/simplified_des_block_encrypt.sv]
// A block is registered on acceptance and its cipher in the result register as stage 1 moves.
// Throughput: one block per cycle unless the output stalls; the cipher is one combinational pass.
// Subkeys are expanded into registers when the key is written.
// Reset (synchronous, active low) empties both stages and loads the subkeys of key 0.
// ----------------------------------------------------------------------------
// simplified_des_block_encrypt
// Two-round simplified DES encryption of 8-bit blocks under a 10-bit key.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module simplified_des_block_encrypt
    import sdes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [KeyW-1:0]     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [BlockW-1:0]   i_plain_block,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BlockW-1:0]   o_cipher_block
);

    logic    r_s1_valid;
    t_block  r_s1_block;
    logic    r_out_valid;
    t_block  r_out_block;
    t_subkey r_k1;
    t_subkey r_k2;

    logic    s1_adv;
    logic    s1_move;
    logic    in_acc;
    t_block  n_out_block;

    assign s1_adv      = !r_out_valid || i_out_ready;
    assign s1_move     = r_s1_valid && s1_adv;
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign in_acc      = i_in_valid && o_in_ready;
    assign n_out_block = f_encrypt(r_s1_block, r_k1, r_k2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_k1        <= '0;
            r_k2        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_k1 <= f_subkey1(i_cfg_data);
                r_k2 <= f_subkey2(i_cfg_data);
            end
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_block <= i_plain_block;
        end
        if (s1_move) begin
            r_out_block <= n_out_block;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cipher_block = r_out_block;

    `SDES_ASSERT(a_accept_fills_s1, in_acc |=> r_s1_valid, "accepted block lost")
    `SDES_ASSERT(a_s1_hold, !o_in_ready |=> (r_s1_valid && $stable(r_s1_block)), "block not held")
    `SDES_ASSERT(a_out_fill, s1_move |=> o_out_valid, "result not raised")
    `SDES_ASSERT(a_result, s1_move |=> o_cipher_block == $past(n_out_block), "result mismatch")

endmodule

[tb/sdes_cipher_checker.sv]
// ----------------------------------------------------------------------------
// sdes_cipher_checker
// Watches the key, block and cipher channels of the S-DES encryptor, works
// out the expected cipher block for every accepted plaintext transaction and
// compares each result transaction, in order, with the oldest one waiting.
// ----------------------------------------------------------------------------
module sdes_cipher_checker
    import sdes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  t_key        i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_block      i_plain_block,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_block      i_cipher_block,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // S-box rows, indexed [row][column]
    localparam logic [1:0] SB0 [4][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd3, 2'd2, 2'd1, 2'd0},
        '{2'd0, 2'd2, 2'd1, 2'd3},
        '{2'd3, 2'd1, 2'd0, 2'd2}
    };
    localparam logic [1:0] SB1 [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd2, 2'd3, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1, 2'd2},
        '{2'd2, 2'd1, 2'd0, 2'd3}
    };

    t_key   cur_key;
    t_block cipher_queue [$];

    function automatic t_key rotate_halves(input t_key k);
        return {k[8:5], k[9], k[3:0], k[4]};
    endfunction

    function automatic t_subkey select_subkey(input t_key k);
        return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
    endfunction

    function automatic t_half feistel(input t_half r, input t_subkey sk);
        t_subkey    e;
        logic [1:0] sa;
        logic [1:0] sb;
        t_half      s;
        e  = {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]} ^ sk;
        sa = SB0[{e[7], e[4]}][{e[6], e[5]}];
        sb = SB1[{e[3], e[0]}][{e[2], e[1]}];
        s  = {sa, sb};
        return {s[2], s[0], s[1], s[3]};
    endfunction

    function automatic t_block encrypt_block(input t_block pt, input t_key key);
        t_key    p10;
        t_key    r1;
        t_key    r2;
        t_block  ip;
        t_block  blk;
        t_half   l;
        t_half   t;
        p10 = {key[7], key[5], key[8], key[3], key[6],
               key[0], key[9], key[1], key[2], key[4]};
        r1  = rotate_halves(p10);
        r2  = rotate_halves(r1);
        ip  = {pt[6], pt[2], pt[5], pt[7], pt[4], pt[0], pt[3], pt[1]};
        // first round, swap, second round
        l   = ip[7:4] ^ feistel(ip[3:0], select_subkey(r1));
        t   = ip[3:0] ^ feistel(l, select_subkey(r2));
        blk = {t, l};
        return {blk[4], blk[7], blk[5], blk[3], blk[1], blk[6], blk[0], blk[2]};
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        cur_key      = '0;
    end

    always @(posedge i_clk) begin
        t_block want;
        if (!i_rst_n) begin
            cur_key = '0;
            cipher_queue.delete();
        end else begin
            // the key in force at this edge applies to a block taken here
            if (i_in_valid && i_in_ready) begin
                cipher_queue.push_back(encrypt_block(i_plain_block, cur_key));
            end
            if (i_cfg_we) begin
                cur_key = i_cfg_data;
            end
            if (i_out_valid && i_out_ready) begin
                if (cipher_queue.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    if (o_fail_count <= 10) begin
                        $display("%0t: unexpected cipher block %02h, none pending",
                                 $realtime, i_cipher_block);
                    end
                end else begin
                    want = cipher_queue.pop_front();
                    o_checked = o_checked + 1;
                    if (i_cipher_block !== want) begin
                        o_fail_count = o_fail_count + 1;
                        if (o_fail_count <= 10) begin
                            $display("%0t: cipher block expected %02h, got %02h",
                                     $realtime, want, i_cipher_block);
                        end
                    end
                end
            end
        end
        o_pending = cipher_queue.size();
    end

endmodule

[tb/simplified_des_block_encrypt_tb.sv]
// ----------------------------------------------------------------------------
// simplified_des_block_encrypt_tb
// Drives plaintext blocks and key writes into the S-DES encryptor with random
// gaps and back-pressure; a checker beside the block predicts every cipher
// block and reports mismatches. Directed blocks and keys come first, then
// phases of random blocks under all-zero, random and all-one keys.
// ----------------------------------------------------------------------------
module simplified_des_block_encrypt_tb;
    import sdes_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int DIR_ITEMS   = 16;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_key   i_cfg_data;
    logic   i_in_valid;
    logic   o_in_ready;
    t_block i_plain_block;
    logic   o_out_valid;
    logic   i_out_ready;
    t_block o_cipher_block;

    int     fail_count;
    int     pending;
    int     checked;
    logic   calm;
    int     blocks_sent;
    int     key_writes;

    simplified_des_block_encrypt dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_plain_block  (i_plain_block),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_cipher_block (o_cipher_block)
    );

    sdes_cipher_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_plain_block  (i_plain_block),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_cipher_block (o_cipher_block),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: stall at random unless in a calm stretch
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_ready <= i_rst_n && (calm || $urandom_range(99) >= 27);
        end
    end

    initial begin
        #2_000_000;
        $display("simplified_des_block_encrypt: mismatch");
        $finish;
    end

    // Called just after a falling edge; returns just after a falling edge
    task automatic send_block(input t_block blk);
        while (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_plain_block <= blk;
        do @(posedge i_clk); while (!o_in_ready);
        blocks_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every expected cipher block has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_key(input t_key key);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= key;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        key_writes++;
    endtask

    initial begin
        t_block dir_blocks [DIR_ITEMS] = '{
            8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55,
            8'h00, 8'hFF, 8'h0F, 8'hF0,
            8'h00, 8'hFF, 8'h5A,
            8'hA5, 8'h3C,
            8'h00
        };
        t_key   dir_keys [DIR_ITEMS] = '{
            10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000,
            10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF,
            10'h155, 10'h155, 10'h155,
            10'h2AA, 10'h2AA,
            10'h000
        };
        t_key   phase_key;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_plain_block = '0;
        calm          = 1'b0;
        blocks_sent   = 0;
        key_writes    = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset key first, then the extremes and alternating keys
        for (int i = 0; i < DIR_ITEMS; i++) begin
            if (i == DIR_ITEMS - 1 || (i > 0 && dir_keys[i] != dir_keys[i-1])) begin
                write_key(dir_keys[i]);
            end
            send_block(dir_blocks[i]);
        end

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) phase_key = 10'h000;
            else if (p == PHASES - 1) phase_key = 10'h3FF;
            else phase_key = t_key'($urandom_range(1023));
            write_key(phase_key);
            calm = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2) begin
                    drain();
                end
                send_block(t_block'($urandom_range(255)));
            end
        end
        calm = 1'b0;

        drain();
        repeat (6) @(negedge i_clk);

        $display("Encrypted %0d blocks under %0d key writes; %0d cipher blocks checked.",
                 blocks_sent, key_writes, checked);
        $display("Keys covered all-zero, all-one, alternating and random values.");
        if (fail_count == 0 && pending == 0) begin
            $display("simplified_des_block_encrypt: match");
        end else begin
            $display("simplified_des_block_encrypt: mismatch");
        end
        $finish;
    end

endmodule

[simplified_des_block_encrypt.f]
+incdir+design
design/sdes_pkg.sv
design/simplified_des_block_encrypt.sv
tb/sdes_cipher_checker.sv
tb/simplified_des_block_encrypt_tb.sv
